// File: hdl/trqt_pkg.sv
// Shared constants, types and codes of the quarter-turn tile rotator.
`default_nettype none
package trqt_pkg;

    // Tile geometry (side may range from 2 to 8)
    localparam int TILE_SIDE = 8;
    localparam int TILE_AREA = TILE_SIDE * TILE_SIDE;
    localparam int IDX_W     = $clog2(TILE_AREA);

    // Fixed field widths
    localparam int PIX_W   = 8;
    localparam int COORD_W = 3;
    localparam int TURN_W  = 2;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_QUARTER_TURNS = 1'b0;  // register index, paddr[2]

    // Command queue between front and back
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // Rotation codes
    typedef logic [TURN_W-1:0] t_turns;
    localparam t_turns TURN_NONE = 2'd0;
    localparam t_turns TURN_CW90 = 2'd1;
    localparam t_turns TURN_180  = 2'd2;
    localparam t_turns TURN_CW270 = 2'd3;

    // Write into the tile store
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [PIX_W-1:0] data;
    } t_store_wr;

    // One full tile ready for emission
    typedef struct packed {
        t_turns turns;
    } t_cmd;

    // Queue status seen by the producer
    typedef struct packed {
        logic full;
    } t_q_stat;

    // Queue status seen by the consumer
    typedef struct packed {
        logic empty;
        t_cmd head;
    } t_q_head;

    // Back end status returned to the front end
    typedef struct packed {
        logic done;   // last store read of the tile issued
    } t_back_stat;

endpackage
`default_nettype wire

// File: hdl/trqt_front.sv
// Front end: accepts pixels, writes the tile store, queues a finished tile.
`default_nettype none
module trqt_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_pixel_valid,
    output logic                 o_pixel_stall,
    input  wire  [7:0]           i_pixel_in,
    input  trqt_pkg::t_turns     i_turns,
    input  trqt_pkg::t_q_stat    i_q_stat,
    input  trqt_pkg::t_back_stat i_back_stat,
    output trqt_pkg::t_store_wr  o_store_wr,
    output logic                 o_push,
    output trqt_pkg::t_cmd       o_cmd
);

    localparam logic [trqt_pkg::IDX_W-1:0] LAST_IDX =
        trqt_pkg::IDX_W'(trqt_pkg::TILE_AREA - 1);

    logic [trqt_pkg::IDX_W-1:0] r_load_cnt, n_load_cnt;
    logic                       r_busy, n_busy;
    logic                       accept;
    logic                       tile_done;

    // Hold off while the single buffer is being read out or the command queue is full
    assign o_pixel_stall = r_busy | i_q_stat.full;
    assign accept        = i_pixel_valid & ~o_pixel_stall;
    assign tile_done     = accept & (r_load_cnt == LAST_IDX);

    // Store write
    assign o_store_wr.en   = accept;
    assign o_store_wr.addr = r_load_cnt;
    assign o_store_wr.data = i_pixel_in;

    // Rotation applied is the one held when the last pixel lands
    assign o_push      = tile_done;
    assign o_cmd.turns = i_turns;

    always_comb begin
        n_load_cnt = r_load_cnt;
        n_busy     = r_busy;
        if (accept) begin
            n_load_cnt = tile_done ? '0 : r_load_cnt + 1'b1;
        end
        if (tile_done) begin
            n_busy = 1'b1;
        end else if (i_back_stat.done) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
            r_busy     <= 1'b0;
        end else begin
            r_load_cnt <= n_load_cnt;
            r_busy     <= n_busy;
        end
    end

endmodule
`default_nettype wire

// File: hdl/trqt_cmd_fifo.sv
// Short command queue between the front end and the back end.
`default_nettype none
module trqt_cmd_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  trqt_pkg::t_cmd      i_cmd,
    input  wire                 i_pop,
    output trqt_pkg::t_q_stat   o_stat,
    output trqt_pkg::t_q_head   o_head
);

    localparam logic [trqt_pkg::CMD_CNT_W-1:0] FULL_CNT =
        trqt_pkg::CMD_CNT_W'(trqt_pkg::CMD_DEPTH);
    localparam logic [trqt_pkg::CMD_PTR_W-1:0] LAST_PTR =
        trqt_pkg::CMD_PTR_W'(trqt_pkg::CMD_DEPTH - 1);

    trqt_pkg::t_cmd                 r_entry [trqt_pkg::CMD_DEPTH];
    logic [trqt_pkg::CMD_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [trqt_pkg::CMD_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [trqt_pkg::CMD_CNT_W-1:0] r_count, n_count;
    logic                           do_push, do_pop;

    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_head.empty = (r_count == '0);
    assign o_head.head  = r_entry[r_rd_ptr];

    assign do_push = i_push & ~o_stat.full;
    assign do_pop  = i_pop & ~o_head.empty;

    // Pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// File: hdl/trqt_back.sv
// Back end: tile store, rotated read-out sequencer and output register.
`default_nettype none
module trqt_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  trqt_pkg::t_store_wr   i_store_wr,
    input  trqt_pkg::t_q_head     i_q_head,
    output logic                  o_pop,
    output trqt_pkg::t_back_stat  o_stat,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic [7:0]            o_pixel_out,
    output logic [2:0]            o_out_row,
    output logic [2:0]            o_out_col,
    output logic                  o_tile_last
);

    localparam logic [trqt_pkg::COORD_W-1:0] SIDE_M1 =
        trqt_pkg::COORD_W'(trqt_pkg::TILE_SIDE - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [trqt_pkg::PIX_W-1:0] r_mem [trqt_pkg::TILE_AREA];

    trqt_pkg::t_turns               r_turns, n_turns;
    logic [trqt_pkg::COORD_W-1:0]   r_row, n_row, r_col, n_col;

    // Read stage
    logic                           r_s1_vld, n_s1_vld;
    logic [trqt_pkg::COORD_W-1:0]   r_s1_row, r_s1_col;
    logic                           r_s1_last;
    logic [trqt_pkg::PIX_W-1:0]     r_rd_data;

    // Output stage
    logic                           r_out_vld, n_out_vld;
    logic [trqt_pkg::PIX_W-1:0]     r_out_pix;
    logic [trqt_pkg::COORD_W-1:0]   r_out_row, r_out_col;
    logic                           r_out_last;

    logic                           advance;
    logic                           issue;
    logic                           at_last;
    logic [trqt_pkg::IDX_W-1:0]     rd_addr;

    // Store index of the pixel that lands at (r, c)
    function automatic logic [trqt_pkg::IDX_W-1:0] src_index(
        input trqt_pkg::t_turns             turns,
        input logic [trqt_pkg::COORD_W-1:0] r,
        input logic [trqt_pkg::COORD_W-1:0] c
    );
        logic [trqt_pkg::COORD_W-1:0] sr;
        logic [trqt_pkg::COORD_W-1:0] sc;
        case (turns)
            trqt_pkg::TURN_CW90: begin
                sr = SIDE_M1 - c;
                sc = r;
            end
            trqt_pkg::TURN_180: begin
                sr = SIDE_M1 - r;
                sc = SIDE_M1 - c;
            end
            trqt_pkg::TURN_CW270: begin
                sr = c;
                sc = SIDE_M1 - r;
            end
            default: begin
                sr = r;
                sc = c;
            end
        endcase
        return trqt_pkg::IDX_W'(int'(sr) * trqt_pkg::TILE_SIDE + int'(sc));
    endfunction

    // Whole pipeline moves together when the output slot frees up
    assign advance = ~r_out_vld | ~i_out_stall;
    assign issue   = (r_state == ST_RUN) & advance;
    assign at_last = (r_row == SIDE_M1) & (r_col == SIDE_M1);
    assign rd_addr = src_index(r_turns, r_row, r_col);

    assign o_pop       = (r_state == ST_IDLE) & ~i_q_head.empty;
    assign o_stat.done = issue & at_last;

    // Read-out sequencer
    always_comb begin
        n_state   = r_state;
        n_turns   = r_turns;
        n_row     = r_row;
        n_col     = r_col;
        n_s1_vld  = r_s1_vld;
        n_out_vld = r_out_vld;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_head.empty) begin
                    n_state = ST_RUN;
                    n_turns = i_q_head.head.turns;
                    n_row   = '0;
                    n_col   = '0;
                end
            end
            ST_RUN: begin
                if (advance) begin
                    if (at_last) begin
                        n_state = ST_IDLE;
                    end
                    if (r_col == SIDE_M1) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (advance) begin
            n_s1_vld  = issue;
            n_out_vld = r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Sequencer payload
    always_ff @(posedge i_clk) begin
        r_turns <= n_turns;
        r_row   <= n_row;
        r_col   <= n_col;
    end

    // Tile store write port
    always_ff @(posedge i_clk) begin
        if (i_store_wr.en) begin
            r_mem[i_store_wr.addr] <= i_store_wr.data;
        end
    end

    // Tile store read port with registered data
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= r_mem[rd_addr];
            r_s1_row  <= r_row;
            r_s1_col  <= r_col;
            r_s1_last <= at_last;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_pix  <= r_rd_data;
            r_out_row  <= r_s1_row;
            r_out_col  <= r_s1_col;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_pixel_out = r_out_pix;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_tile_last = r_out_last;

endmodule
`default_nettype wire

// File: hdl/tile_rotate_quarter_turn_core.sv
// Top level of the quarter-turn tile rotator: register port and block wiring.
//
// Usage:
//   Pixels of a square 8x8 tile enter in row-major order on the input channel
//   (i_pixel_valid / o_pixel_stall / i_pixel_in), one transaction per pixel.
//   When the last pixel arrives the whole tile leaves on the output channel
//   (o_out_valid / i_out_stall) in row-major order, rotated clockwise by the
//   quarter_turns register, with its row, column and a last flag on the final
//   pixel. quarter_turns sits at byte address 0 of the APB-style port.
// Timing:
//   Pixels load one per cycle while the input is not stalled. After the last
//   pixel is taken the rotated pixels follow, one per cycle while the receiver
//   does not stall. The single tile buffer keeps loading and emission apart:
//   input is stalled from the last pixel of a tile until the read-out
//   sequencer has issued its last store read.
// Reset and stall:
//   Reset drops a partial tile and any emission in progress and clears the
//   register to 0. A stall from the receiver freezes the read-out pipeline;
//   no pixel is lost or repeated.
`default_nettype none
module tile_rotate_quarter_turn_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel input
    input  wire         i_pixel_valid,
    output logic        o_pixel_stall,
    input  wire  [7:0]  i_pixel_in,
    // rotated pixel output
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [7:0]  o_pixel_out,
    output logic [2:0]  o_out_row,
    output logic [2:0]  o_out_col,
    output logic        o_tile_last
);

    trqt_pkg::t_turns     r_turns;
    logic                 cfg_wr;
    trqt_pkg::t_store_wr  store_wr;
    trqt_pkg::t_cmd       cmd;
    logic                 push;
    logic                 pop;
    trqt_pkg::t_q_stat    q_stat;
    trqt_pkg::t_q_head    q_head;
    trqt_pkg::t_back_stat back_stat;

    // Register port, zero wait states
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready &
                    (paddr[2] == trqt_pkg::REG_QUARTER_TURNS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turns <= trqt_pkg::TURN_NONE;
        end else if (cfg_wr) begin
            r_turns <= pwdata[trqt_pkg::TURN_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == trqt_pkg::REG_QUARTER_TURNS) begin
            prdata = trqt_pkg::APB_DATA_W'(r_turns);
        end else begin
            prdata = '0;
        end
    end

    trqt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_stall (o_pixel_stall),
        .i_pixel_in    (i_pixel_in),
        .i_turns       (r_turns),
        .i_q_stat      (q_stat),
        .i_back_stat   (back_stat),
        .o_store_wr    (store_wr),
        .o_push        (push),
        .o_cmd         (cmd)
    );

    trqt_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_head  (q_head)
    );

    trqt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_store_wr  (store_wr),
        .i_q_head    (q_head),
        .o_pop       (pop),
        .o_stat      (back_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pixel_out (o_pixel_out),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_tile_last (o_tile_last)
    );

endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// Testbench for the quarter-turn tile rotator: directed tiles against a rotation predictor.
module tb;

    localparam int HALF_PERIOD = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LATENCY_PAD = 8;
    localparam int MAX_REPORTS = 40;

    localparam logic [trqt_pkg::APB_ADDR_W-1:0] ADDR_TURNS  =
        {trqt_pkg::REG_QUARTER_TURNS, 2'b00};
    localparam logic [trqt_pkg::APB_ADDR_W-1:0] ADDR_UNUSED =
        {~trqt_pkg::REG_QUARTER_TURNS, 2'b00};

    // One rotated pixel as it should leave the block
    typedef struct packed {
        logic [trqt_pkg::PIX_W-1:0]   pixel;
        logic [trqt_pkg::COORD_W-1:0] row;
        logic [trqt_pkg::COORD_W-1:0] col;
        logic                         tile_end;
    } t_rot_pixel;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [trqt_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [trqt_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [trqt_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            i_pixel_valid = 1'b0;
    logic                            o_pixel_stall;
    logic [trqt_pkg::PIX_W-1:0]      i_pixel_in = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [trqt_pkg::PIX_W-1:0]      o_pixel_out;
    logic [trqt_pkg::COORD_W-1:0]    o_out_row;
    logic [trqt_pkg::COORD_W-1:0]    o_out_col;
    logic                            o_tile_last;

    // Predictor state: tile copy, fill level and rotation setting
    logic [trqt_pkg::PIX_W-1:0] tile_copy [trqt_pkg::TILE_AREA];
    int                         pixels_loaded = 0;
    trqt_pkg::t_turns           turn_setting = trqt_pkg::TURN_NONE;
    t_rot_pixel                 rotated_expected [$];

    int          error_count = 0;
    int unsigned cycle_count = 0;
    bit          gaps_on = 1'b1;

    tile_rotate_quarter_turn_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_stall (o_pixel_stall),
        .i_pixel_in    (i_pixel_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_out   (o_pixel_out),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_tile_last   (o_tile_last)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= gaps_on && ($urandom_range(0, 99) < 7);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("tb: mismatch on %s: got %0d, want %0d (cycle %0d)",
                     what, got, want, cycle_count);
    endtask

    // Store index of the pixel that lands at (r, c) after the rotation
    function automatic int source_index(input trqt_pkg::t_turns turns,
                                        input int r, input int c);
        int sr;
        int sc;
        case (turns)
            trqt_pkg::TURN_CW90: begin
                sr = trqt_pkg::TILE_SIDE - 1 - c;
                sc = r;
            end
            trqt_pkg::TURN_180: begin
                sr = trqt_pkg::TILE_SIDE - 1 - r;
                sc = trqt_pkg::TILE_SIDE - 1 - c;
            end
            trqt_pkg::TURN_CW270: begin
                sr = c;
                sc = trqt_pkg::TILE_SIDE - 1 - r;
            end
            default: begin
                sr = r;
                sc = c;
            end
        endcase
        return sr * trqt_pkg::TILE_SIDE + sc;
    endfunction

    // Output checker: each transaction against the oldest expected pixel
    always @(posedge i_clk) begin
        t_rot_pixel want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rotated_expected.size() == 0) begin
                report_mismatch("unexpected pixel", o_pixel_out, -1);
            end else begin
                want = rotated_expected.pop_front();
                if (o_pixel_out !== want.pixel)
                    report_mismatch("pixel_out", o_pixel_out, want.pixel);
                if (o_out_row !== want.row)
                    report_mismatch("out_row", o_out_row, want.row);
                if (o_out_col !== want.col)
                    report_mismatch("out_col", o_out_col, want.col);
                if (o_tile_last !== want.tile_end)
                    report_mismatch("tile_last", o_tile_last, want.tile_end);
            end
        end
    end

    // Register write: setup then access phase; called and returns at a falling edge
    task automatic apb_write(input logic [trqt_pkg::APB_ADDR_W-1:0] addr,
                             input logic [trqt_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr[2] == trqt_pkg::REG_QUARTER_TURNS)
            turn_setting = data[trqt_pkg::TURN_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Register read: data taken at the access edge
    task automatic apb_read(input  logic [trqt_pkg::APB_ADDR_W-1:0] addr,
                            output logic [trqt_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Send one pixel; on the last pixel of a tile, queue the rotated tile
    task automatic send_pixel(input logic [trqt_pkg::PIX_W-1:0] pix);
        t_rot_pixel e;
        while (gaps_on && $urandom_range(0, 99) < 7) begin
            i_pixel_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_pixel_valid <= 1'b1;
        i_pixel_in    <= pix;
        @(posedge i_clk);
        while (o_pixel_stall) @(posedge i_clk);
        tile_copy[pixels_loaded] = pix;
        if (pixels_loaded == trqt_pkg::TILE_AREA - 1) begin
            pixels_loaded = 0;
            for (int r = 0; r < trqt_pkg::TILE_SIDE; r++) begin
                for (int c = 0; c < trqt_pkg::TILE_SIDE; c++) begin
                    e.pixel    = tile_copy[source_index(turn_setting, r, c)];
                    e.row      = trqt_pkg::COORD_W'(r);
                    e.col      = trqt_pkg::COORD_W'(c);
                    e.tile_end = (r == trqt_pkg::TILE_SIDE - 1) &&
                                 (c == trqt_pkg::TILE_SIDE - 1);
                    rotated_expected.push_back(e);
                end
            end
        end else begin
            pixels_loaded++;
        end
        @(negedge i_clk);
    endtask

    task automatic hold_pixels();
        i_pixel_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Wait for every expected pixel, then let the read-out pipeline settle
    task automatic wait_drained();
        while (rotated_expected.size() != 0) @(negedge i_clk);
        repeat (LATENCY_PAD) @(negedge i_clk);
    endtask

    // One tile per rotation, with extreme pixel values followed by a ramp
    task automatic test_each_rotation();
        trqt_pkg::t_turns           turns_list [4];
        logic [trqt_pkg::PIX_W-1:0] pix;
        turns_list = '{trqt_pkg::TURN_NONE, trqt_pkg::TURN_CW90,
                       trqt_pkg::TURN_180, trqt_pkg::TURN_CW270};
        for (int t = 0; t < 4; t++) begin
            apb_write(ADDR_TURNS,
                      {{(trqt_pkg::APB_DATA_W-trqt_pkg::TURN_W){1'b0}}, turns_list[t]});
            for (int k = 0; k < trqt_pkg::TILE_AREA; k++) begin
                case (k)
                    0: pix = 8'h00;
                    1: pix = 8'hFF;
                    2: pix = 8'h55;
                    3: pix = 8'hAA;
                    default: pix = trqt_pkg::PIX_W'(k * 3 + t + 7);
                endcase
                send_pixel(pix);
            end
            hold_pixels();
            wait_drained();
        end
    endtask

    // Upper data bits are dropped, and a write to the unused address is ignored
    task automatic test_register_decode();
        logic [trqt_pkg::APB_DATA_W-1:0] rd;
        apb_write(ADDR_TURNS,
                  {{(trqt_pkg::APB_DATA_W-trqt_pkg::TURN_W){1'b1}}, trqt_pkg::TURN_180});
        apb_write(ADDR_UNUSED,
                  {{(trqt_pkg::APB_DATA_W-trqt_pkg::TURN_W){1'b0}}, trqt_pkg::TURN_CW90});
        apb_read(ADDR_TURNS, rd);
        if (rd !== trqt_pkg::APB_DATA_W'(turn_setting))
            report_mismatch("prdata", rd, turn_setting);
    endtask

    // Rotation changed halfway through a tile: the value at the last pixel wins.
    // Random gaps on both sides are switched off here.
    task automatic test_midtile_write();
        gaps_on = 1'b0;
        apb_write(ADDR_TURNS,
                  {{(trqt_pkg::APB_DATA_W-trqt_pkg::TURN_W){1'b0}}, trqt_pkg::TURN_CW90});
        for (int k = 0; k < trqt_pkg::TILE_AREA; k++) begin
            if (k == trqt_pkg::TILE_AREA / 2) begin
                hold_pixels();
                wait_drained();
                apb_write(ADDR_TURNS,
                          {{(trqt_pkg::APB_DATA_W-trqt_pkg::TURN_W){1'b0}},
                           trqt_pkg::TURN_CW270});
            end
            send_pixel($urandom_range(0, 255));
        end
        hold_pixels();
        wait_drained();
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_each_rotation();
        test_register_decode();
        test_midtile_write();

        if (error_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/trqt_pkg.sv
hdl/trqt_front.sv
hdl/trqt_cmd_fifo.sv
hdl/trqt_back.sv
hdl/tile_rotate_quarter_turn_core.sv
test/tb.sv
